@@ rtl/sbm_pkg.sv @@
// Package for the swept bilinear minimum sampler.
// Holds default sizes, field widths, register indexes and shared types.
// Depends on nothing; every other file imports it.
`timescale 1ns / 1ps

package sbm_pkg;

    // Default sizes of the image store and of the sweep.
    localparam int DEF_MAX_WIDTH     = 256;
    localparam int DEF_MAX_HEIGHT    = 256;
    localparam int DEF_MAX_TRAVEL    = 255;
    localparam int DEF_FRACTION_BITS = 8;

    // Fixed field widths.
    localparam int VALUE_W    = 32;
    localparam int COORD_W    = 8;
    localparam int SIZE_W     = 9;
    localparam int DRAG_W     = 17;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 17;

    // The largest Q16.16 value stands for infinity.
    localparam logic signed [VALUE_W-1:0] VALUE_INF = 32'sh7FFF_FFFF;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 4'd0,
        CFG_IMAGE_HEIGHT = 4'd1,
        CFG_DRAG_X       = 4'd2,
        CFG_DRAG_Y       = 4'd3
    } t_cfg_idx;

    // Status of the sample pipeline seen by the sequencer.
    typedef struct packed {
        logic busy;
        logic valid;
    } t_pipe_stat;

endpackage

@@ rtl/sbm_divider.sv @@
// Restoring divider that produces one quotient bit per cycle.
// Used to split a drag magnitude into whole and remainder steps per sample.
// Depends on sbm_pkg.
`timescale 1ns / 1ps

module sbm_divider import sbm_pkg::*; #(
    parameter int DW = DRAG_W,
    parameter int TW = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [TW-1:0] i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_quot,
    output logic [TW-1:0] o_rem
);

    localparam int CW = $clog2(DW + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_num;
    logic [DW-1:0] r_quot;
    logic [TW-1:0] r_rem;
    logic [TW:0]   w_trial;
    logic          w_fits;

    // Shift the next dividend bit into the partial remainder and try a subtract.
    assign w_trial = {r_rem, r_num[DW-1]};
    assign w_fits  = (w_trial >= {1'b0, i_divisor});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num  <= i_dividend;
            r_rem  <= '0;
            r_quot <= '0;
        end else if (r_busy) begin
            r_num  <= {r_num[DW-2:0], 1'b0};
            r_quot <= {r_quot[DW-2:0], w_fits};
            r_rem  <= w_fits ? TW'(w_trial - {1'b0, i_divisor}) : TW'(w_trial);
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

endmodule

@@ rtl/sbm_sample_pipe.sv @@
// Six-stage bilinear sample pipeline with the image store inside it.
// Checks bounds, reads four neighbours, blends rows then columns.
// Depends on sbm_pkg.
`timescale 1ns / 1ps

module sbm_sample_pipe import sbm_pkg::*; #(
    parameter int MAX_WIDTH     = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT    = DEF_MAX_HEIGHT,
    parameter int FRACTION_BITS = DEF_FRACTION_BITS,
    parameter int XW            = 8,
    parameter int YW            = 8,
    parameter int PW            = 20
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_wr_en,
    input  logic [XW-1:0]             i_wr_x,
    input  logic [YW-1:0]             i_wr_y,
    input  logic [VALUE_W-1:0]        i_wr_data,
    input  logic                      i_smp_valid,
    input  logic signed [PW-1:0]      i_qx,
    input  logic signed [PW-1:0]      i_qy,
    input  logic [SIZE_W-1:0]         i_width,
    input  logic [SIZE_W-1:0]         i_height,
    output t_pipe_stat                o_stat,
    output logic signed [VALUE_W-1:0] o_value
);

    localparam int F     = FRACTION_BITS;
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int DFW   = VALUE_W + 1;
    localparam int PRW   = DFW + F + 1;
    localparam int HALF  = 1 << (F - 1);

    // Four copies of the store give four reads in one cycle.
    logic [VALUE_W-1:0] r_mem0 [DEPTH];
    logic [VALUE_W-1:0] r_mem1 [DEPTH];
    logic [VALUE_W-1:0] r_mem2 [DEPTH];
    logic [VALUE_W-1:0] r_mem3 [DEPTH];

    logic              r_v1, r_v2, r_v3, r_v4, r_v5, r_v6;
    logic              r_o1, r_o2, r_o3, r_o4, r_o5;
    logic [XW-1:0]     r_x0, r_x1;
    logic [YW-1:0]     r_y0, r_y1;
    logic [F-1:0]      r_xr1, r_yr1, r_xr2, r_yr2, r_yr3, r_yr4;
    logic signed [VALUE_W-1:0] r_q00, r_q10, r_q01, r_q11;
    logic signed [VALUE_W-1:0] r_q00_3, r_q01_3;
    logic signed [PRW-1:0]     r_pn, r_ps, r_pv;
    logic signed [VALUE_W-1:0] r_n4, r_s4, r_n5, r_val6;

    logic signed [PW-1:0]      w_xlim, w_ylim;
    logic                      w_out;
    logic [PW-1:0]             w_x0u, w_y0u;
    logic [XW-1:0]             w_x1;
    logic [YW-1:0]             w_y1;
    logic [AW-1:0]             w_wa, w_a00, w_a10, w_a01, w_a11;
    logic signed [DFW-1:0]     w_dn, w_ds, w_dv;
    logic signed [PRW-1:0]     w_pn, w_ps, w_pv;
    logic signed [VALUE_W-1:0] w_n, w_s, w_val;

    // Stage 1: bounds check, neighbour coordinates with edge clamp, fractions.
    assign w_xlim = $signed(PW'(i_width) << F);
    assign w_ylim = $signed(PW'(i_height) << F);
    assign w_out  = (i_qx < 0) || (i_qy < 0) || (i_qx >= w_xlim) || (i_qy >= w_ylim);
    assign w_x0u  = PW'(unsigned'(i_qx) >> F);
    assign w_y0u  = PW'(unsigned'(i_qy) >> F);
    assign w_x1   = ((w_x0u + PW'(1)) < PW'(i_width)) ? XW'(w_x0u + PW'(1))
                                                      : XW'(PW'(i_width) - PW'(1));
    assign w_y1   = ((w_y0u + PW'(1)) < PW'(i_height)) ? YW'(w_y0u + PW'(1))
                                                       : YW'(PW'(i_height) - PW'(1));

    always_ff @(posedge i_clk) begin
        r_o1  <= w_out;
        r_x0  <= XW'(w_x0u);
        r_y0  <= YW'(w_y0u);
        r_x1  <= w_x1;
        r_y1  <= w_y1;
        r_xr1 <= i_qx[F-1:0];
        r_yr1 <= i_qy[F-1:0];
    end

    // Stage 2: store addresses and registered reads; loads write every copy.
    assign w_wa  = AW'(i_wr_y) * AW'(MAX_WIDTH) + AW'(i_wr_x);
    assign w_a00 = AW'(r_y0) * AW'(MAX_WIDTH) + AW'(r_x0);
    assign w_a10 = AW'(r_y0) * AW'(MAX_WIDTH) + AW'(r_x1);
    assign w_a01 = AW'(r_y1) * AW'(MAX_WIDTH) + AW'(r_x0);
    assign w_a11 = AW'(r_y1) * AW'(MAX_WIDTH) + AW'(r_x1);

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem0[w_wa] <= i_wr_data;
            r_mem1[w_wa] <= i_wr_data;
            r_mem2[w_wa] <= i_wr_data;
            r_mem3[w_wa] <= i_wr_data;
        end
        r_q00 <= $signed(r_mem0[w_a00]);
        r_q10 <= $signed(r_mem1[w_a10]);
        r_q01 <= $signed(r_mem2[w_a01]);
        r_q11 <= $signed(r_mem3[w_a11]);
        r_o2  <= r_o1;
        r_xr2 <= r_xr1;
        r_yr2 <= r_yr1;
    end

    // Stage 3: horizontal weight times neighbour difference, both rows.
    assign w_dn = DFW'(r_q10) - DFW'(r_q00);
    assign w_ds = DFW'(r_q11) - DFW'(r_q01);
    assign w_pn = PRW'(w_dn) * PRW'($signed({1'b0, r_xr2}));
    assign w_ps = PRW'(w_ds) * PRW'($signed({1'b0, r_xr2}));

    always_ff @(posedge i_clk) begin
        r_pn    <= w_pn;
        r_ps    <= w_ps;
        r_q00_3 <= r_q00;
        r_q01_3 <= r_q01;
        r_o3    <= r_o2;
        r_yr3   <= r_yr2;
    end

    // Stage 4: round each row blend half up back to Q16.16.
    assign w_n = r_q00_3 + VALUE_W'((r_pn + PRW'(HALF)) >>> F);
    assign w_s = r_q01_3 + VALUE_W'((r_ps + PRW'(HALF)) >>> F);

    always_ff @(posedge i_clk) begin
        r_n4  <= w_n;
        r_s4  <= w_s;
        r_o4  <= r_o3;
        r_yr4 <= r_yr3;
    end

    // Stage 5: vertical weight times the row difference.
    assign w_dv = DFW'(r_s4) - DFW'(r_n4);
    assign w_pv = PRW'(w_dv) * PRW'($signed({1'b0, r_yr4}));

    always_ff @(posedge i_clk) begin
        r_pv <= w_pv;
        r_n5 <= r_n4;
        r_o5 <= r_o4;
    end

    // Stage 6: final rounding; a point outside the image reads as infinity.
    assign w_val = r_o5 ? VALUE_INF : r_n5 + VALUE_W'((r_pv + PRW'(HALF)) >>> F);

    always_ff @(posedge i_clk) begin
        r_val6 <= w_val;
    end

    // Valid bits travel alongside the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else begin
            r_v1 <= i_smp_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
        end
    end

    assign o_stat.busy  = r_v1 | r_v2 | r_v3 | r_v4 | r_v5 | r_v6;
    assign o_stat.valid = r_v6;
    assign o_value      = r_val6;

endmodule

@@ rtl/swept_bilinear_min_sampler.sv @@
// Swept bilinear minimum sampler, top level: ports, registers, sequencer.
// Uses sbm_pkg, sbm_divider and sbm_sample_pipe.
// A compute runs one divider bit per cycle, then issues one sample per cycle
// into the six-stage pipe. A zero drag gives its result in the cycle after
// start. Results are shown for one cycle on o_valid; the receiver cannot
// stall. Reset (i_rst_n, synchronous) sets width and height to 256 and the
// drags to 0; the store is not cleared.
`timescale 1ns / 1ps

module swept_bilinear_min_sampler import sbm_pkg::*; #(
    parameter int MAX_WIDTH     = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT    = DEF_MAX_HEIGHT,
    parameter int MAX_TRAVEL    = DEF_MAX_TRAVEL,
    parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic                      i_mode,
    input  logic [COORD_W-1:0]        i_pixel_x,
    input  logic [COORD_W-1:0]        i_pixel_y,
    input  logic signed [VALUE_W-1:0] i_load_value,
    output logic                      o_valid,
    output logic signed [VALUE_W-1:0] o_min_value,
    output logic [COORD_W-1:0]        o_out_x,
    output logic [COORD_W-1:0]        o_out_y,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int F   = FRACTION_BITS;
    localparam int TW  = $clog2(MAX_TRAVEL + 1);
    localparam int XW  = $clog2(MAX_WIDTH);
    localparam int YW  = $clog2(MAX_HEIGHT);
    localparam int P0  = (COORD_W + F > DRAG_W) ? COORD_W + F : DRAG_W;
    localparam int P1  = (F + XW > P0) ? F + XW : P0;
    localparam int P2  = (F + YW > P1) ? F + YW : P1;
    localparam int P3  = (F + SIZE_W > P2) ? F + SIZE_W : P2;
    localparam int PW  = P3 + 2;
    localparam int RAW_W = DRAG_W + 1;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_DIV   = 4'b0010,
        S_RUN   = 4'b0100,
        S_DRAIN = 4'b1000
    } t_state;

    t_state                    r_state, n_state;
    logic [SIZE_W-1:0]         r_img_w, r_img_h;
    logic signed [DRAG_W-1:0]  r_drag_x, r_drag_y;
    logic [DRAG_W-1:0]         r_ax, r_ay;
    logic                      r_sx, r_sy;
    logic [TW-1:0]             r_travel, r_i;
    logic [COORD_W-1:0]        r_px, r_py;
    logic [DRAG_W-1:0]         r_qoff_x, r_qoff_y;
    logic [TW-1:0]             r_roff_x, r_roff_y;
    logic                      r_div_go;
    logic                      r_smp_valid;
    logic signed [PW-1:0]      r_qx, r_qy;
    logic signed [VALUE_W-1:0] r_best;
    logic                      r_out_valid;
    logic signed [VALUE_W-1:0] r_out_min;
    logic [COORD_W-1:0]        r_out_x, r_out_y;

    logic                      w_accept, w_compute;
    logic [DRAG_W-1:0]         w_ax, w_ay, w_amax;
    logic [RAW_W-1:0]          w_raw;
    logic [TW-1:0]             w_travel;
    logic [SIZE_W-1:0]         w_width, w_height;
    logic                      w_wr_en;
    logic                      w_done_x, w_done_y;
    logic [DRAG_W-1:0]         w_qa_x, w_qa_y;
    logic [TW-1:0]             w_ra_x, w_ra_y;
    logic [TW:0]               w_rsum_x, w_rsum_y;
    logic                      w_wrap_x, w_wrap_y;
    logic signed [PW-1:0]      w_base_x, w_base_y, w_off_x, w_off_y;
    t_pipe_stat                w_stat;
    logic signed [VALUE_W-1:0] w_value;
    logic signed [VALUE_W-1:0] w_best;

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_accept    = start && !busy;
    assign w_compute   = w_accept && i_mode;

    // Configuration registers; an unknown index is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w  <= SIZE_W'(256);
            r_img_h  <= SIZE_W'(256);
            r_drag_x <= '0;
            r_drag_y <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_IMAGE_WIDTH:  r_img_w  <= i_cfg_data[SIZE_W-1:0];
                CFG_IMAGE_HEIGHT: r_img_h  <= i_cfg_data[SIZE_W-1:0];
                CFG_DRAG_X:       r_drag_x <= $signed(i_cfg_data);
                CFG_DRAG_Y:       r_drag_y <= $signed(i_cfg_data);
                default:          ;
            endcase
        end
    end

    // Image size in use, limited to the store.
    assign w_width  = (int'(r_img_w) > MAX_WIDTH) ? SIZE_W'(MAX_WIDTH) : r_img_w;
    assign w_height = (int'(r_img_h) > MAX_HEIGHT) ? SIZE_W'(MAX_HEIGHT) : r_img_h;

    // Travel is the larger drag magnitude rounded up to whole pixels, limited to MAX_TRAVEL.
    assign w_ax     = r_drag_x[DRAG_W-1] ? DRAG_W'(-r_drag_x) : DRAG_W'(r_drag_x);
    assign w_ay     = r_drag_y[DRAG_W-1] ? DRAG_W'(-r_drag_y) : DRAG_W'(r_drag_y);
    assign w_amax   = (w_ax > w_ay) ? w_ax : w_ay;
    assign w_raw    = ({1'b0, w_amax} + RAW_W'((1 << F) - 1)) >> F;
    assign w_travel = (w_raw > RAW_W'(MAX_TRAVEL)) ? TW'(MAX_TRAVEL) : TW'(w_raw);

    // A load writes the store at once when its position lies inside it.
    assign w_wr_en = w_accept && !i_mode && (int'(i_pixel_x) < MAX_WIDTH)
                     && (int'(i_pixel_y) < MAX_HEIGHT);

    // Split each magnitude into whole and remainder steps per sample.
    sbm_divider #(
        .DW (DRAG_W),
        .TW (TW)
    ) u_div_x (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_go),
        .i_dividend (r_ax),
        .i_divisor  (r_travel),
        .o_done     (w_done_x),
        .o_quot     (w_qa_x),
        .o_rem      (w_ra_x)
    );

    sbm_divider #(
        .DW (DRAG_W),
        .TW (TW)
    ) u_div_y (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_go),
        .i_dividend (r_ay),
        .i_divisor  (r_travel),
        .o_done     (w_done_y),
        .o_quot     (w_qa_y),
        .o_rem      (w_ra_y)
    );

    // Offset stepping: floor(a * i / travel) advanced by quotient and remainder.
    assign w_rsum_x = {1'b0, r_roff_x} + {1'b0, w_ra_x};
    assign w_rsum_y = {1'b0, r_roff_y} + {1'b0, w_ra_y};
    assign w_wrap_x = (w_rsum_x >= {1'b0, r_travel});
    assign w_wrap_y = (w_rsum_y >= {1'b0, r_travel});

    assign w_base_x = $signed(PW'(r_px) << F);
    assign w_base_y = $signed(PW'(r_py) << F);
    assign w_off_x  = $signed(PW'(r_qoff_x));
    assign w_off_y  = $signed(PW'(r_qoff_y));

    // Sequencer state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_compute && (w_travel != '0)) n_state = S_DIV;
            end
            S_DIV: begin
                if (w_done_x) n_state = S_RUN;
            end
            S_RUN: begin
                if (r_i == r_travel - 1'b1) n_state = S_DRAIN;
            end
            S_DRAIN: begin
                if (!r_smp_valid && !w_stat.busy) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_div_go    <= 1'b0;
            r_smp_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_div_go    <= (r_state == S_IDLE) && w_compute && (w_travel != '0);
            r_smp_valid <= (r_state == S_RUN);
            r_out_valid <= ((r_state == S_IDLE) && w_compute && (w_travel == '0))
                           || ((r_state == S_DRAIN) && (n_state == S_IDLE));
        end
    end

    // Request capture, stepping and sample issue.
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && w_compute) begin
            r_px     <= i_pixel_x;
            r_py     <= i_pixel_y;
            r_ax     <= w_ax;
            r_ay     <= w_ay;
            r_sx     <= r_drag_x[DRAG_W-1];
            r_sy     <= r_drag_y[DRAG_W-1];
            r_travel <= w_travel;
        end
        if (r_state == S_DIV) begin
            r_i      <= '0;
            r_qoff_x <= '0;
            r_qoff_y <= '0;
            r_roff_x <= '0;
            r_roff_y <= '0;
        end else if (r_state == S_RUN) begin
            r_i      <= r_i + 1'b1;
            r_qoff_x <= r_qoff_x + w_qa_x + DRAG_W'(w_wrap_x);
            r_qoff_y <= r_qoff_y + w_qa_y + DRAG_W'(w_wrap_y);
            r_roff_x <= w_wrap_x ? TW'(w_rsum_x - {1'b0, r_travel}) : TW'(w_rsum_x);
            r_roff_y <= w_wrap_y ? TW'(w_rsum_y - {1'b0, r_travel}) : TW'(w_rsum_y);
        end
        r_qx <= r_sx ? w_base_x + w_off_x : w_base_x - w_off_x;
        r_qy <= r_sy ? w_base_y + w_off_y : w_base_y - w_off_y;
    end

    sbm_sample_pipe #(
        .MAX_WIDTH     (MAX_WIDTH),
        .MAX_HEIGHT    (MAX_HEIGHT),
        .FRACTION_BITS (FRACTION_BITS),
        .XW            (XW),
        .YW            (YW),
        .PW            (PW)
    ) u_pipe (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr_en     (w_wr_en),
        .i_wr_x      (XW'(i_pixel_x)),
        .i_wr_y      (YW'(i_pixel_y)),
        .i_wr_data   (i_load_value),
        .i_smp_valid (r_smp_valid),
        .i_qx        (r_qx),
        .i_qy        (r_qy),
        .i_width     (w_width),
        .i_height    (w_height),
        .o_stat      (w_stat),
        .o_value     (w_value)
    );

    // Running minimum over the samples of one request.
    assign w_best = (w_stat.valid && (w_value < r_best)) ? w_value : r_best;

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE) begin
            r_best <= VALUE_INF;
        end else begin
            r_best <= w_best;
        end
        if (r_state == S_IDLE) begin
            r_out_min <= VALUE_INF;
            r_out_x   <= i_pixel_x;
            r_out_y   <= i_pixel_y;
        end else if (r_state == S_DRAIN) begin
            r_out_min <= w_best;
            r_out_x   <= r_px;
            r_out_y   <= r_py;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_min_value = r_out_min;
    assign o_out_x     = r_out_x;
    assign o_out_y     = r_out_y;

    // Both dividers run in lockstep.
    a_div_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done_x == w_done_y)
        else $error("dividers finished in different cycles");

    // Samples are issued only while the sweep runs.
    a_issue_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_smp_valid |-> $past(r_state) == S_RUN)
        else $error("sample issued outside the sweep");

    // Pipeline results arrive only during a sweep or its drain.
    a_result_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.valid |-> (r_state == S_RUN || r_state == S_DRAIN))
        else $error("sample result outside a compute request");

    // The step counter stays below the travel.
    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_RUN |-> r_i < r_travel)
        else $error("step counter passed the travel");

endmodule
